// ===== hw/rtl/itoa_pkg.sv =====
// shared types, constants and helpers for the integer to ascii formatter
package itoa_pkg;

    localparam int VALUE_W     = 64;
    localparam int DEC_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 31;
    localparam int NIB_W       = 4;
    localparam int HEX_DIGITS  = VALUE_W / NIB_W;
    localparam int DEC_DIGITS  = 10;
    localparam int BCD_W       = DEC_DIGITS * NIB_W;
    localparam int LEFT_W      = 5;
    localparam int STEP_W      = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0]  CASE_GAP   = 8'h20;
    localparam logic [NIB_W-1:0]   RADIX_DEC  = 4'd10;
    localparam logic [NIB_W-1:0]   DABBLE_MIN = 4'd5;
    localparam logic [NIB_W-1:0]   DABBLE_ADD = 4'd3;

    localparam logic [LEFT_W-1:0]  DEC_LEFT   = LEFT_W'(DEC_DIGITS);
    localparam logic [LEFT_W-1:0]  HEX_LEFT   = LEFT_W'(HEX_DIGITS);
    localparam logic [STEP_W-1:0]  DEC_STEPS  = STEP_W'(DEC_W - 1);

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_ALIGN,
        ST_EMIT
    } itoa_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib,
                                                      input logic lc);
        logic [CHAR_W-1:0] code;
        if (nib < RADIX_DEC)
        begin
            code = CHAR_ZERO + CHAR_W'(nib);
        end
        else
        begin
            code = CHAR_UPPER + CHAR_W'(nib - RADIX_DEC) + (lc ? CASE_GAP : '0);
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/itoa_if.sv =====
// valid/ready channels for number words in and character words out
interface itoa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [itoa_pkg::VALUE_W-1:0]  value;
    logic                          lower_case;

    modport source (output valid, operation, value, lower_case, input ready);
    modport sink   (input valid, operation, value, lower_case, output ready);
endinterface

interface itoa_out_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;
    logic [itoa_pkg::COUNT_W-1:0]  total_chars;

    modport source (output valid, char_code, last_char, total_chars, input ready);
    modport sink   (input valid, char_code, last_char, total_chars, output ready);
endinterface

// ===== hw/rtl/integer_to_ascii_formatter_core.sv =====
// integer to ascii formatter: one number word in, one character word out per digit
// Takes one number word at a time and writes it out as ASCII digits, most
// significant first, without leading zeros, one character word per digit with
// the final one flagged and a saturating running character count attached.
// Decimal mode converts value[31:0] with a shift-and-add-3 unit that runs one
// bit per cycle; then leading zero digits are dropped one at a time (at least one
// digit is kept), and then the characters are emitted one at a time. Hex mode
// skips the conversion and goes straight to dropping leading zeros and emitting.
// Emitting a character also waits as long as the output register still holds a
// word the receiver has not taken. The input is ready only in the idle state,
// while no word is being converted or emitted; the last character sits in an
// output register so the next word can be taken while it waits.
module integer_to_ascii_formatter_core (
    input logic   clk,
    input logic   rst_n,
    itoa_in_if.sink    req,
    itoa_out_if.source rsp
);
    import itoa_pkg::*;

    itoa_state_t               state_reg, state_next;
    logic [DEC_W-1:0]          bin_reg, bin_next;
    logic [VALUE_W-1:0]        digit_reg, digit_next;
    logic [LEFT_W-1:0]         left_reg, left_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      lc_reg, lc_next;
    logic [COUNT_W-1:0]        total_reg, total_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]         out_char_reg, out_char_next;
    logic                      out_last_reg, out_last_next;

    logic [BCD_W-1:0]          bcd_fix;
    logic [BCD_W-1:0]          bcd_shift;
    logic                      out_free;

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (digit_reg[i*NIB_W +: NIB_W] >= DABBLE_MIN)
            begin
                bcd_fix[i*NIB_W +: NIB_W] = digit_reg[i*NIB_W +: NIB_W] + DABBLE_ADD;
            end
            else
            begin
                bcd_fix[i*NIB_W +: NIB_W] = digit_reg[i*NIB_W +: NIB_W];
            end
        end
        bcd_shift = {bcd_fix[BCD_W-2:0], bin_reg[DEC_W-1]};
    end

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        digit_next     = digit_reg;
        left_next      = left_reg;
        step_next      = step_reg;
        lc_next        = lc_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        req.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    lc_next = req.lower_case;
                    if (req.operation == OP_HEX)
                    begin
                        digit_next = req.value;
                        left_next  = HEX_LEFT;
                        state_next = ST_ALIGN;
                    end
                    else
                    begin
                        bin_next   = req.value[DEC_W-1:0];
                        digit_next = '0;
                        step_next  = DEC_STEPS;
                        state_next = ST_DABBLE;
                    end
                end
            end
            ST_DABBLE:
            begin
                bin_next = {bin_reg[DEC_W-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    digit_next = {bcd_shift, {(VALUE_W - BCD_W){1'b0}}};
                    left_next  = DEC_LEFT;
                    state_next = ST_ALIGN;
                end
                else
                begin
                    digit_next = {{(VALUE_W - BCD_W){1'b0}}, bcd_shift};
                    step_next  = step_reg - 1'b1;
                end
            end
            ST_ALIGN:
            begin
                // drop leading zero digits, keep at least one
                if (digit_reg[VALUE_W-1 -: NIB_W] == '0 && left_reg > LEFT_W'(1))
                begin
                    digit_next = {digit_reg[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
                    left_next  = left_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(digit_reg[VALUE_W-1 -: NIB_W], lc_reg);
                    out_last_next  = (left_reg == LEFT_W'(1));
                    if (total_reg != COUNT_MAX)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    digit_next = {digit_reg[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
                    left_next  = left_reg - 1'b1;
                    if (left_reg == LEFT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            step_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        digit_reg    <= digit_next;
        lc_reg       <= lc_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.char_code   = out_char_reg;
    assign rsp.last_char   = out_last_reg;
    assign rsp.total_chars = total_reg;

endmodule
